/* rtl/htlm_pkg.sv */
`default_nettype none
package htlm_pkg;

   // default sizes
   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_ARITY_DEF = 16;
   localparam int ID_BITS_DEF   = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ARITY      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NODE_COUNT = 2'd1;
   localparam int ARITY_RESET = 2;

   // request codes
   localparam logic [1:0] OP_LOCK    = 2'd0;
   localparam logic [1:0] OP_UNLOCK  = 2'd1;
   localparam logic [1:0] OP_UPGRADE = 2'd2;

   // controller states
   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_PATH,
      S_PATH_DIV,
      S_PATH_OK,
      S_UNL_CHK,
      S_INC,
      S_INC_DIV,
      S_INC_RD,
      S_DEC,
      S_DEC_DIV,
      S_DEC_RD,
      S_SC_SET,
      S_LEVEL,
      S_SCAN_RD,
      S_SCAN_NEXT,
      S_NX1,
      S_NX2
   } state_type;

   // datapath actions
   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_RD_NODE,
      ACT_DIV,
      ACT_STEP_UP,
      ACT_INC,
      ACT_DEC,
      ACT_SETLK,
      ACT_CLRV,
      ACT_MUL_NODE,
      ACT_SET_LOHI,
      ACT_MUL_LO,
      ACT_SET_LO,
      ACT_SET_HI,
      ACT_LEVEL,
      ACT_JNEXT,
      ACT_PICK_J,
      ACT_CLR
   } act_type;

   typedef struct packed {
      act_type act;
      logic    path_chk;
      logic    rel_set;
      logic    finish;
      logic    ok;
   } cmd_type;

   typedef struct packed {
      logic       range_bad;
      logic [1:0] op;
      logic       cur_zero;
      logic       div_done;
      logic       rd_valid;
      logic       owner_match;
      logic       cnt_zero;
      logic       lo_done;
      logic       j_last;
      logic       release_pass;
      logic       clr_last;
   } status_type;

endpackage
`default_nettype wire

/* rtl/htlm_div.sv */
`default_nettype none
module htlm_div #(
   parameter int NB = 10,
   parameter int AB = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NB-1:0] dividend,
   input  wire logic [AB-1:0] divisor,
   output logic               done,
   output logic [NB-1:0]      quotient
);

   localparam int KB = $clog2(NB + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [KB-1:0] cnt_ff, cnt_in;
   logic [AB-1:0] rem_ff, rem_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [AB:0]   trial;
   logic          ge;
   logic [NB:0]   shifted;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[NB-1]};
      ge      = trial >= {1'b0, divisor};
      shifted = {quo_ff, ge};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = KB'(NB);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? AB'(trial - {1'b0, divisor}) : trial[AB-1:0];
         quo_in = shifted[NB-1:0];
         cnt_in = cnt_ff - KB'(1);
         if (cnt_ff == KB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* rtl/htlm_ctl.sv */
`default_nettype none
module htlm_ctl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             cfg_wr,
   input  wire htlm_pkg::status_type st,
   output htlm_pkg::cmd_type     cmd,
   output logic                  busy
);

   htlm_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htlm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.act      = htlm_pkg::ACT_NONE;
      cmd.path_chk = 1'b0;
      cmd.rel_set  = 1'b0;
      cmd.finish   = 1'b0;
      cmd.ok       = 1'b0;
      unique case (state_ff)
         htlm_pkg::S_CLEAR: begin
            cmd.act = htlm_pkg::ACT_CLR;
            if (st.clr_last) state_in = htlm_pkg::S_IDLE;
         end
         htlm_pkg::S_IDLE: begin
            if (start) begin
               cmd.act  = htlm_pkg::ACT_LOAD;
               state_in = htlm_pkg::S_DISPATCH;
            end
         end
         htlm_pkg::S_DISPATCH: begin
            priority if (st.range_bad) begin
               cmd.finish = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end else if (st.op == htlm_pkg::OP_LOCK || st.op == htlm_pkg::OP_UPGRADE) begin
               cmd.act  = htlm_pkg::ACT_RD_NODE;
               state_in = htlm_pkg::S_PATH;
            end else if (st.op == htlm_pkg::OP_UNLOCK) begin
               cmd.act  = htlm_pkg::ACT_RD_NODE;
               state_in = htlm_pkg::S_UNL_CHK;
            end else begin
               cmd.finish = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end
         end
         // ancestor chain must be free
         htlm_pkg::S_PATH: begin
            cmd.path_chk = 1'b1;
            priority if (st.rd_valid) begin
               cmd.finish = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end else if (st.cur_zero) begin
               state_in = htlm_pkg::S_PATH_OK;
            end else begin
               cmd.act  = htlm_pkg::ACT_DIV;
               state_in = htlm_pkg::S_PATH_DIV;
            end
         end
         htlm_pkg::S_PATH_DIV: begin
            if (st.div_done) begin
               cmd.act  = htlm_pkg::ACT_STEP_UP;
               state_in = htlm_pkg::S_PATH;
            end
         end
         htlm_pkg::S_PATH_OK: begin
            priority if (st.op == htlm_pkg::OP_LOCK && st.cnt_zero) begin
               cmd.act  = htlm_pkg::ACT_RD_NODE;
               state_in = htlm_pkg::S_INC;
            end else if (st.op == htlm_pkg::OP_UPGRADE && !st.cnt_zero) begin
               cmd.act  = htlm_pkg::ACT_MUL_NODE;
               state_in = htlm_pkg::S_SC_SET;
            end else begin
               cmd.finish = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end
         end
         htlm_pkg::S_UNL_CHK: begin
            if (st.rd_valid && st.owner_match) begin
               cmd.act  = htlm_pkg::ACT_RD_NODE;
               state_in = htlm_pkg::S_DEC;
            end else begin
               cmd.finish = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end
         end
         // count the new lock in every ancestor, then take the node
         htlm_pkg::S_INC: begin
            if (st.cur_zero) begin
               cmd.act    = htlm_pkg::ACT_SETLK;
               cmd.finish = 1'b1;
               cmd.ok     = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end else begin
               cmd.act  = htlm_pkg::ACT_DIV;
               state_in = htlm_pkg::S_INC_DIV;
            end
         end
         htlm_pkg::S_INC_DIV: begin
            if (st.div_done) begin
               cmd.act  = htlm_pkg::ACT_STEP_UP;
               state_in = htlm_pkg::S_INC_RD;
            end
         end
         htlm_pkg::S_INC_RD: begin
            cmd.act  = htlm_pkg::ACT_INC;
            state_in = htlm_pkg::S_INC;
         end
         // release a lock: uncount it in the ancestors, then drop it
         htlm_pkg::S_DEC: begin
            if (st.cur_zero) begin
               cmd.act = htlm_pkg::ACT_CLRV;
               if (st.release_pass) begin
                  state_in = htlm_pkg::S_SCAN_NEXT;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.ok     = 1'b1;
                  state_in   = htlm_pkg::S_IDLE;
               end
            end else begin
               cmd.act  = htlm_pkg::ACT_DIV;
               state_in = htlm_pkg::S_DEC_DIV;
            end
         end
         htlm_pkg::S_DEC_DIV: begin
            if (st.div_done) begin
               cmd.act  = htlm_pkg::ACT_STEP_UP;
               state_in = htlm_pkg::S_DEC_RD;
            end
         end
         htlm_pkg::S_DEC_RD: begin
            cmd.act  = htlm_pkg::ACT_DEC;
            state_in = htlm_pkg::S_DEC;
         end
         // descendant scan, one level range at a time
         htlm_pkg::S_SC_SET: begin
            cmd.act  = htlm_pkg::ACT_SET_LOHI;
            state_in = htlm_pkg::S_LEVEL;
         end
         htlm_pkg::S_LEVEL: begin
            priority if (!st.lo_done) begin
               cmd.act  = htlm_pkg::ACT_LEVEL;
               state_in = htlm_pkg::S_SCAN_RD;
            end else if (!st.release_pass) begin
               cmd.act     = htlm_pkg::ACT_MUL_NODE;
               cmd.rel_set = 1'b1;
               state_in    = htlm_pkg::S_SC_SET;
            end else begin
               cmd.act  = htlm_pkg::ACT_RD_NODE;
               state_in = htlm_pkg::S_INC;
            end
         end
         htlm_pkg::S_SCAN_RD: begin
            priority if (!st.rd_valid) begin
               state_in = htlm_pkg::S_SCAN_NEXT;
            end else if (st.release_pass) begin
               cmd.act  = htlm_pkg::ACT_PICK_J;
               state_in = htlm_pkg::S_DEC;
            end else if (st.owner_match) begin
               state_in = htlm_pkg::S_SCAN_NEXT;
            end else begin
               cmd.finish = 1'b1;
               state_in   = htlm_pkg::S_IDLE;
            end
         end
         htlm_pkg::S_SCAN_NEXT: begin
            if (st.j_last) begin
               cmd.act  = htlm_pkg::ACT_MUL_LO;
               state_in = htlm_pkg::S_NX1;
            end else begin
               cmd.act  = htlm_pkg::ACT_JNEXT;
               state_in = htlm_pkg::S_SCAN_RD;
            end
         end
         htlm_pkg::S_NX1: begin
            cmd.act  = htlm_pkg::ACT_SET_LO;
            state_in = htlm_pkg::S_NX2;
         end
         htlm_pkg::S_NX2: begin
            cmd.act  = htlm_pkg::ACT_SET_HI;
            state_in = htlm_pkg::S_LEVEL;
         end
         default: begin
            state_in = htlm_pkg::S_CLEAR;
         end
      endcase
      // a register write reshapes the tree and wipes every lock
      if (cfg_wr) state_in = htlm_pkg::S_CLEAR;
   end

   assign busy = state_ff != htlm_pkg::S_IDLE;

endmodule
`default_nettype wire

/* rtl/htlm_dp.sv */
`default_nettype none
module htlm_dp #(
   parameter int MAX_NODES = htlm_pkg::MAX_NODES_DEF,
   parameter int MAX_ARITY = htlm_pkg::MAX_ARITY_DEF,
   parameter int ID_BITS   = htlm_pkg::ID_BITS_DEF,
   parameter int NB        = $clog2(MAX_NODES),
   parameter int AB        = $clog2(MAX_ARITY + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cfg_wr,
   input  wire logic [htlm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [htlm_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic [1:0]                          req_type,
   input  wire logic [NB-1:0]                       req_node_index,
   input  wire logic [ID_BITS-1:0]                  req_user_id,
   input  wire htlm_pkg::cmd_type                   cmd,
   output htlm_pkg::status_type                     st,
   output logic                                     rsp_valid,
   output logic                                     rsp_success
);

   localparam int CB = NB + 1;
   localparam int PB = CB + AB;

   // configuration
   logic [AB-1:0] arity_ff;
   logic [CB-1:0] ncount_ff;
   logic [AB-1:0] a_eff;
   logic [CB-1:0] n_eff, n_m1;

   // request and walk registers
   logic [1:0]         op_ff, op_in;
   logic [NB-1:0]      node_ff, node_in;
   logic [ID_BITS-1:0] user_ff, user_in;
   logic [NB-1:0]      cur_ff, cur_in;
   logic [NB-1:0]      base_ff, base_in;
   logic [NB-1:0]      j_ff, j_in;
   logic [NB-1:0]      top_ff, top_in;
   logic [CB-1:0]      lo_ff, lo_in;
   logic [CB-1:0]      hi_ff, hi_in;
   logic [PB-1:0]      prod_ff, prod_in;
   logic [NB-1:0]      addr_ff, addr_in;
   logic [NB-1:0]      clr_ff, clr_in;
   logic               rel_ff, rel_in;
   logic               cntz_ff, cntz_in;
   logic               rsp_valid_ff, rsp_success_ff;

   // node tables
   logic               valid_mem_ff [MAX_NODES];
   logic [NB-1:0]      count_mem_ff [MAX_NODES];
   logic [ID_BITS-1:0] owner_mem_ff [MAX_NODES];
   logic               v_rd_ff;
   logic [NB-1:0]      c_rd_ff;
   logic [ID_BITS-1:0] o_rd_ff;
   logic               v_we, v_wd, c_we, o_we;
   logic [NB-1:0]      v_wa, c_wa, c_wd;

   logic [CB-1:0]      mul_x;
   logic [PB:0]        sum_one, sum_a;
   logic               div_done;
   logic [NB-1:0]      div_q;

   function automatic logic [CB-1:0] sat_node(input logic [PB:0] v);
      if (v > (PB+1)'(MAX_NODES)) return CB'(MAX_NODES);
      return v[CB-1:0];
   endfunction

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         arity_ff  <= AB'(htlm_pkg::ARITY_RESET);
         ncount_ff <= CB'(MAX_NODES);
      end else if (cfg_wr) begin
         if (csr_index == htlm_pkg::REG_ARITY) arity_ff <= csr_wdata[AB-1:0];
         if (csr_index == htlm_pkg::REG_NODE_COUNT) ncount_ff <= csr_wdata[CB-1:0];
      end
   end

   // effective tree shape
   always_comb begin
      if (arity_ff == '0) a_eff = AB'(1);
      else if (arity_ff > AB'(MAX_ARITY)) a_eff = AB'(MAX_ARITY);
      else a_eff = arity_ff;
      if (ncount_ff == '0) n_eff = CB'(1);
      else if (ncount_ff > CB'(MAX_NODES)) n_eff = CB'(MAX_NODES);
      else n_eff = ncount_ff;
      n_m1 = n_eff - CB'(1);
   end

   // parent index unit
   htlm_div #(
      .NB (NB),
      .AB (AB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.act == htlm_pkg::ACT_DIV),
      .dividend (cur_ff - NB'(1)),
      .divisor  (a_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   // datapath next values
   always_comb begin
      op_in   = op_ff;
      node_in = node_ff;
      user_in = user_ff;
      cur_in  = cur_ff;
      base_in = base_ff;
      j_in    = j_ff;
      top_in  = top_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      addr_in = addr_ff;
      clr_in  = clr_ff;
      rel_in  = rel_ff;
      cntz_in = cntz_ff;
      v_we    = 1'b0;
      v_wa    = node_ff;
      v_wd    = 1'b0;
      c_we    = 1'b0;
      c_wa    = cur_ff;
      c_wd    = c_rd_ff;
      o_we    = 1'b0;
      mul_x   = lo_ff;
      sum_one = {1'b0, prod_ff} + (PB+1)'(1);
      sum_a   = {1'b0, prod_ff} + (PB+1)'(a_eff);
      unique case (cmd.act)
         htlm_pkg::ACT_NONE: begin
         end
         htlm_pkg::ACT_LOAD: begin
            op_in   = req_type;
            node_in = req_node_index;
            user_in = req_user_id;
            rel_in  = 1'b0;
         end
         htlm_pkg::ACT_RD_NODE: begin
            cur_in  = node_ff;
            base_in = node_ff;
            addr_in = node_ff;
         end
         htlm_pkg::ACT_DIV: begin
         end
         htlm_pkg::ACT_STEP_UP: begin
            cur_in  = div_q;
            addr_in = div_q;
         end
         htlm_pkg::ACT_INC: begin
            c_we = 1'b1;
            c_wd = c_rd_ff + NB'(1);
         end
         htlm_pkg::ACT_DEC: begin
            c_we = 1'b1;
            c_wd = (c_rd_ff != '0) ? c_rd_ff - NB'(1) : c_rd_ff;
         end
         htlm_pkg::ACT_SETLK: begin
            v_we = 1'b1;
            v_wd = 1'b1;
            o_we = 1'b1;
         end
         htlm_pkg::ACT_CLRV: begin
            v_we = 1'b1;
            v_wa = base_ff;
         end
         htlm_pkg::ACT_MUL_NODE: begin
            mul_x = {1'b0, node_ff};
         end
         htlm_pkg::ACT_SET_LOHI: begin
            lo_in = sat_node(sum_one);
            hi_in = sat_node(sum_a);
         end
         htlm_pkg::ACT_MUL_LO: begin
            mul_x = lo_ff;
         end
         htlm_pkg::ACT_SET_LO: begin
            lo_in = sat_node(sum_one);
            mul_x = hi_ff;
         end
         htlm_pkg::ACT_SET_HI: begin
            hi_in = sat_node(sum_a);
         end
         htlm_pkg::ACT_LEVEL: begin
            j_in    = lo_ff[NB-1:0];
            addr_in = lo_ff[NB-1:0];
            top_in  = (hi_ff < n_m1) ? hi_ff[NB-1:0] : n_m1[NB-1:0];
         end
         htlm_pkg::ACT_JNEXT: begin
            j_in    = j_ff + NB'(1);
            addr_in = j_ff + NB'(1);
         end
         htlm_pkg::ACT_PICK_J: begin
            cur_in  = j_ff;
            base_in = j_ff;
         end
         htlm_pkg::ACT_CLR: begin
            v_we   = 1'b1;
            v_wa   = clr_ff;
            c_we   = 1'b1;
            c_wa   = clr_ff;
            c_wd   = '0;
            clr_in = clr_ff + NB'(1);
         end
         default: begin
         end
      endcase
      prod_in = {{AB{1'b0}}, mul_x} * {{CB{1'b0}}, a_eff};
      if (cmd.rel_set) rel_in = 1'b1;
      if (cmd.path_chk && cur_ff == node_ff) cntz_in = c_rd_ff == '0;
      if (cfg_wr) clr_in = '0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff         <= '0;
         rel_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clr_ff         <= clr_in;
         rel_ff         <= rel_in;
         rsp_valid_ff   <= cmd.finish;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      node_ff <= node_in;
      user_ff <= user_in;
      cur_ff  <= cur_in;
      base_ff <= base_in;
      j_ff    <= j_in;
      top_ff  <= top_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      prod_ff <= prod_in;
      addr_ff <= addr_in;
      cntz_ff <= cntz_in;
      if (cmd.finish) rsp_success_ff <= cmd.ok;
   end

   // table memories, registered reads
   always_ff @(posedge clock) begin
      if (v_we) valid_mem_ff[v_wa] <= v_wd;
      v_rd_ff <= valid_mem_ff[addr_in];
   end

   always_ff @(posedge clock) begin
      if (c_we) count_mem_ff[c_wa] <= c_wd;
      c_rd_ff <= count_mem_ff[addr_in];
   end

   always_ff @(posedge clock) begin
      if (o_we) owner_mem_ff[node_ff] <= user_ff;
      o_rd_ff <= owner_mem_ff[addr_in];
   end

   // status to controller
   always_comb begin
      st.range_bad    = {1'b0, node_ff} >= n_eff;
      st.op           = op_ff;
      st.cur_zero     = cur_ff == '0;
      st.div_done     = div_done;
      st.rd_valid     = v_rd_ff;
      st.owner_match  = o_rd_ff == user_ff;
      st.cnt_zero     = cntz_ff;
      st.lo_done      = lo_ff >= n_eff;
      st.j_last       = j_ff == top_ff;
      st.release_pass = rel_ff;
      st.clr_last     = clr_ff == NB'(MAX_NODES - 1);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_success = rsp_success_ff;

endmodule
`default_nettype wire

/* rtl/hierarchical_tree_lock_manager_core.sv */
`default_nettype none
// Lock manager for a breadth-first numbered M-ary tree.
// Requests: pulse start with req_type, req_node_index and req_user_id while busy
// is low; the word is taken at that edge and busy rises until it is done.
// Results: one word per request, rsp_success valid for the single cycle that
// rsp_valid is high, which is the first cycle that busy is low again. There is
// no backpressure on the result side; the next request may start in that cycle.
// Configuration: csr_valid/csr_ready write channel (always ready), index 0
// arity, index 1 node count. A write to either clears every lock.
// Each ancestor step costs one parent divide plus a path check or a count
// update. An unlock walks the ancestors once, a lock twice. Upgrade adds two
// scans of the subtree, level by level, and an ancestor walk for every lock it
// releases. The iterative parent divider sets the cost of each ancestor step.
// Reset and every register write start a clearing pass over every entry of the
// node tables, during which busy is high.
module hierarchical_tree_lock_manager_core #(
   parameter int MAX_NODES = htlm_pkg::MAX_NODES_DEF,
   parameter int MAX_ARITY = htlm_pkg::MAX_ARITY_DEF,
   parameter int ID_BITS   = htlm_pkg::ID_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_type,
   input  wire logic [$clog2(MAX_NODES)-1:0]        req_node_index,
   input  wire logic [ID_BITS-1:0]                  req_user_id,
   output logic                                     rsp_valid,
   output logic                                     rsp_success,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [htlm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [htlm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   htlm_pkg::cmd_type    cmd;
   htlm_pkg::status_type st;
   logic                 cfg_wr;

   // only writes to known registers reshape the tree
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready &&
                      (csr_index == htlm_pkg::REG_ARITY ||
                       csr_index == htlm_pkg::REG_NODE_COUNT);

   htlm_ctl u_ctl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cfg_wr (cfg_wr),
      .st     (st),
      .cmd    (cmd),
      .busy   (busy)
   );

   htlm_dp #(
      .MAX_NODES (MAX_NODES),
      .MAX_ARITY (MAX_ARITY),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg_wr         (cfg_wr),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_node_index (req_node_index),
      .req_user_id    (req_user_id),
      .cmd            (cmd),
      .st             (st),
      .rsp_valid      (rsp_valid),
      .rsp_success    (rsp_success)
   );

`ifndef SYNTHESIS
   // a result only follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // results are single-cycle strobes
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // an accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");
`endif

endmodule
`default_nettype wire

/* tb/hierarchical_tree_lock_manager_core_tb.sv */
`default_nettype none
module hierarchical_tree_lock_manager_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 1024;
   localparam int ARITY_CAP = 16;
   localparam logic [1:0] OP_BAD = 2'd3;
   localparam logic [htlm_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 30000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [9:0]  req_node_index = '0;
   logic [15:0] req_user_id = '0;
   logic        rsp_valid;
   logic        rsp_success;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [htlm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [htlm_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   hierarchical_tree_lock_manager_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_node_index(req_node_index), .req_user_id(req_user_id),
      .rsp_valid(rsp_valid), .rsp_success(rsp_success),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // lock table shadow
   bit          held[NODES];
   logic [15:0] holder[NODES];
   int          held_below[NODES];
   logic [4:0]  arity_reg = 5'd2;
   logic [10:0] count_reg = 11'd1024;

   bit grant_q[$];
   int fail_count = 0;
   int cycle_count = 0;
   bit burst = 0;

   function automatic int tree_arity();
      if (arity_reg == 0) return 1;
      if (arity_reg > ARITY_CAP) return ARITY_CAP;
      return arity_reg;
   endfunction

   function automatic int tree_size();
      if (count_reg == 0) return 1;
      if (count_reg > NODES) return NODES;
      return count_reg;
   endfunction

   function automatic void wipe_tables();
      for (int k = 0; k < NODES; k++) begin
         held[k] = 0;
         holder[k] = '0;
         held_below[k] = 0;
      end
   endfunction

   // node or an ancestor locked
   function automatic bit chain_held(int i, int a);
      int k;
      k = i;
      forever begin
         if (held[k]) return 1;
         if (k == 0) return 0;
         k = (k - 1) / a;
      end
   endfunction

   function automatic void take_node(int i, logic [15:0] user, int a);
      int k;
      k = i;
      while (k != 0) begin
         k = (k - 1) / a;
         held_below[k]++;
      end
      held[i] = 1;
      holder[i] = user;
   endfunction

   function automatic void drop_node(int i, int a);
      int k;
      k = i;
      while (k != 0) begin
         k = (k - 1) / a;
         if (held_below[k] != 0) held_below[k]--;
      end
      held[i] = 0;
      holder[i] = '0;
   endfunction

   // walk descendants level by level; check ownership or release them
   function automatic bit walk_subtree(int i, logic [15:0] user, int a, int n, bit rel);
      longint lo, hi, top;
      lo = longint'(i) * a + 1;
      hi = longint'(i) * a + a;
      while (lo < n) begin
         top = (hi < n - 1) ? hi : n - 1;
         for (longint j = lo; j <= top; j++) begin
            if (held[j]) begin
               if (rel) drop_node(int'(j), a);
               else if (holder[j] != user) return 0;
            end
         end
         lo = lo * a + 1;
         hi = hi * a + a;
      end
      return 1;
   endfunction

   function automatic bit grant_request(logic [1:0] op, logic [9:0] idx, logic [15:0] user);
      int a, n, i;
      a = tree_arity();
      n = tree_size();
      i = idx;
      if (i >= n) return 0;
      case (op)
         htlm_pkg::OP_LOCK: begin
            if (!chain_held(i, a) && held_below[i] == 0) begin
               take_node(i, user, a);
               return 1;
            end
         end
         htlm_pkg::OP_UNLOCK: begin
            if (held[i] && holder[i] == user) begin
               drop_node(i, a);
               return 1;
            end
         end
         htlm_pkg::OP_UPGRADE: begin
            if (!chain_held(i, a) && held_below[i] != 0 &&
                walk_subtree(i, user, a, n, 0)) begin
               void'(walk_subtree(i, user, a, n, 1));
               take_node(i, user, a);
               return 1;
            end
         end
         default: ;
      endcase
      return 0;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (grant_q.size() == 0) begin
            $error("unexpected response word, success %0b", rsp_success);
            fail_count++;
         end else begin
            if (rsp_success !== grant_q[0]) begin
               $error("success mismatch: expected %0b actual %0b", grant_q[0], rsp_success);
               fail_count++;
            end
            void'(grant_q.pop_front());
         end
      end
   end

   // send one request word
   task automatic send_request(logic [1:0] op, logic [9:0] idx, logic [15:0] user);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      repeat (gap) @(negedge clock);
      while (busy) @(negedge clock);
      start = 1'b1;
      req_type = op;
      req_node_index = idx;
      req_user_id = user;
      @(posedge clock);
      grant_q.insert(grant_q.size(), grant_request(op, idx, user));
      @(negedge clock);
      start = 1'b0;
      req_type = 2'($urandom_range(0, 3));
      req_node_index = 10'($urandom);
      req_user_id = 16'($urandom);
   endtask

   task automatic drain();
      while (grant_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(logic [htlm_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [htlm_pkg::CSR_DATA_BITS-1:0] data);
      drain();
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      if (idx == htlm_pkg::REG_ARITY) begin
         arity_reg = data[4:0];
         wipe_tables();
      end else if (idx == htlm_pkg::REG_NODE_COUNT) begin
         count_reg = data[10:0];
         wipe_tables();
      end
      @(negedge clock);
      csr_valid = 1'b0;
      csr_wdata = $urandom;
      repeat (4) @(negedge clock);
   endtask

   task automatic set_tree(logic [htlm_pkg::CSR_DATA_BITS-1:0] a,
                           logic [htlm_pkg::CSR_DATA_BITS-1:0] n);
      write_reg(htlm_pkg::REG_ARITY, a);
      write_reg(htlm_pkg::REG_NODE_COUNT, n);
   endtask

   // hand-picked sequences on the reset tree
   task automatic test_directed_ops();
      send_request(htlm_pkg::OP_LOCK, 10'd0, 16'h0000);
      send_request(htlm_pkg::OP_LOCK, 10'd1, 16'h0000);
      send_request(htlm_pkg::OP_UNLOCK, 10'd0, 16'hFFFF);
      send_request(htlm_pkg::OP_UNLOCK, 10'd0, 16'h0000);
      send_request(htlm_pkg::OP_LOCK, 10'd1023, 16'hFFFF);
      send_request(htlm_pkg::OP_LOCK, 10'd511, 16'hFFFF);
      send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'hFFFF);
      send_request(htlm_pkg::OP_LOCK, 10'd5, 16'h1234);
      send_request(htlm_pkg::OP_UNLOCK, 10'd0, 16'hFFFF);
      send_request(htlm_pkg::OP_UPGRADE, 10'd0, 16'hFFFF);
      send_request(htlm_pkg::OP_LOCK, 10'd3, 16'h0001);
      send_request(htlm_pkg::OP_LOCK, 10'd4, 16'h0002);
      send_request(htlm_pkg::OP_UPGRADE, 10'd1, 16'h0001);
      send_request(htlm_pkg::OP_UNLOCK, 10'd4, 16'h0002);
      send_request(htlm_pkg::OP_UPGRADE, 10'd1, 16'h0001);
      send_request(htlm_pkg::OP_UPGRADE, 10'd3, 16'h0001);
      send_request(OP_BAD, 10'd2, 16'h0001);
      send_request(OP_BAD, 10'd1, 16'h0001);
      send_request(htlm_pkg::OP_UNLOCK, 10'd1, 16'h0001);
   endtask

   // out-of-range index and the short last level
   task automatic test_bounds();
      set_tree(32'd3, 32'd6);
      send_request(htlm_pkg::OP_LOCK, 10'd6, 16'h0007);
      send_request(htlm_pkg::OP_LOCK, 10'd1023, 16'h0007);
      send_request(htlm_pkg::OP_LOCK, 10'd5, 16'h0007);
      send_request(htlm_pkg::OP_UPGRADE, 10'd1, 16'h0007);
      send_request(htlm_pkg::OP_UNLOCK, 10'd1, 16'h0007);
      // index beyond the register list leaves locks alone
      send_request(htlm_pkg::OP_LOCK, 10'd2, 16'h0008);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_request(htlm_pkg::OP_LOCK, 10'd2, 16'h0009);
      send_request(htlm_pkg::OP_UNLOCK, 10'd2, 16'h0008);
   endtask

   // random traffic on one tree shape
   task automatic test_random_tree(logic [htlm_pkg::CSR_DATA_BITS-1:0] a,
                                   logic [htlm_pkg::CSR_DATA_BITS-1:0] n,
                                   int count);
      logic [15:0] users[4];
      int          locked_q[$];
      logic [1:0]  op;
      logic [9:0]  idx;
      logic [15:0] user;
      int          sz, r;
      users = '{16'h0000, 16'h0001, 16'hFFFF, 16'h5A5A};
      set_tree(a, n);
      sz = tree_size();
      for (int t = 0; t < count; t++) begin
         if (t % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         user = ($urandom_range(0, 9) == 0) ? 16'($urandom) : users[$urandom_range(0, 3)];
         idx = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, sz - 1));
         if (r < 40) op = htlm_pkg::OP_LOCK;
         else if (r < 70) begin
            op = htlm_pkg::OP_UNLOCK;
            locked_q.delete();
            for (int k = 0; k < sz; k++) if (held[k]) locked_q.insert(locked_q.size(), k);
            if (locked_q.size() != 0 && $urandom_range(0, 9) < 7) begin
               idx = 10'(locked_q[$urandom_range(0, locked_q.size() - 1)]);
               user = holder[idx];
            end
         end else if (r < 95) op = htlm_pkg::OP_UPGRADE;
         else op = OP_BAD;
         send_request(op, idx, user);
      end
      burst = 0;
   endtask

   initial begin
      wipe_tables();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (4) @(negedge clock);
      test_directed_ops();
      test_bounds();
      test_random_tree(32'd2, 32'd1024, 120);
      test_random_tree(32'd1, 32'd40, 150);
      test_random_tree(32'd0, 32'd20, 100);
      test_random_tree(32'd3, 32'd100, 200);
      test_random_tree(32'd4, 32'd64, 200);
      test_random_tree(32'd16, 32'd300, 150);
      test_random_tree(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
      test_random_tree(32'd2, 32'd1, 50);
      test_random_tree(32'd5, 32'd0, 50);
      test_random_tree(32'd2, 32'd31, 200);
      test_random_tree(32'($urandom_range(1, 16)), 32'($urandom_range(2, 80)), 150);
      drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
